/* src/i2ra_pkg.sv */
package i2ra_pkg;

  localparam int VALUE_W = 32;
  localparam int BASE_W = 6;
  localparam int CHAR_W = 7;

  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] LAST_DECIMAL = 6'd9;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 7'd55;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] ERR_CHAR = 7'd0;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [BASE_W-1:0] base;
  } in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic last;
    logic bad_base;
  } out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store;
    logic rd;
    logic emit_sign;
    logic emit_digit;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic last_bit;
    logic more;
    logic neg;
    logic cnt_zero;
  } stat_t;

endpackage

/* src/i2ra_dp.sv */
module i2ra_dp #(
  parameter int MAX_DIGITS = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  i2ra_pkg::in_t   in_data,
  input  i2ra_pkg::cmd_t  cmd,
  output i2ra_pkg::stat_t stat,
  output logic            out_valid,
  output i2ra_pkg::out_t  out_data
);

  localparam int VW = i2ra_pkg::VALUE_W;
  localparam int BW = i2ra_pkg::BASE_W;
  localparam int CW = i2ra_pkg::CHAR_W;
  localparam int BIT_W = $clog2(VW);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(VW - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);

  logic [VW-1:0]    quot_r;
  logic [BW-1:0]    rem_r;
  logic [BW-1:0]    base_r;
  logic             neg_r;
  logic [BIT_W-1:0] bit_r;
  logic [CNT_W-1:0] cnt_r;
  logic [BW-1:0]    rd_r;
  logic             out_valid_r;
  i2ra_pkg::out_t   out_r;
  logic [BW-1:0]    mem [MAX_DIGITS];

  logic [VW-1:0]    val_u;
  logic [VW-1:0]    mag;
  logic [BW:0]      trial;
  logic             ge;
  logic [BW:0]      diff;
  logic [CNT_W-1:0] cnt_m1;
  logic [CW-1:0]    digit_char;
  i2ra_pkg::out_t   out_nxt;
  logic             out_valid_nxt;

  assign val_u = in_data.value[VW-1:0];
  assign mag = val_u[VW-1] ? (~val_u + 1'b1) : val_u;
  assign trial = {rem_r, quot_r[VW-1]};
  assign ge = trial >= {1'b0, base_r};
  assign diff = trial - {1'b0, base_r};
  assign cnt_m1 = cnt_r - 1'b1;

  always_comb begin
    if (rd_r > i2ra_pkg::LAST_DECIMAL) begin
      digit_char = i2ra_pkg::LETTER_OFFSET + CW'(rd_r);
    end else begin
      digit_char = i2ra_pkg::ASCII_ZERO + CW'(rd_r);
    end
  end

  assign stat.bad = (base_r < i2ra_pkg::BASE_MIN) || (base_r > i2ra_pkg::BASE_MAX);
  assign stat.last_bit = bit_r == BIT_LAST;
  assign stat.more = (quot_r != '0) && (cnt_r != CNT_LAST);
  assign stat.neg = neg_r;
  assign stat.cnt_zero = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r <= mag;
      neg_r  <= val_u[VW-1];
      base_r <= in_data.base;
      rem_r  <= '0;
      bit_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.div_step) begin
      quot_r <= {quot_r[VW-2:0], ge};
      rem_r  <= ge ? diff[BW-1:0] : trial[BW-1:0];
      bit_r  <= bit_r + 1'b1;
    end else if (cmd.store) begin
      mem[cnt_r[IDX_W-1:0]] <= rem_r;
      cnt_r <= cnt_r + 1'b1;
      rem_r <= '0;
      bit_r <= '0;
    end else if (cmd.rd) begin
      rd_r  <= mem[cnt_m1[IDX_W-1:0]];
      cnt_r <= cnt_m1;
    end
  end

  always_comb begin
    out_nxt = out_r;
    out_valid_nxt = 1'b0;
    if (cmd.emit_err) begin
      out_valid_nxt = 1'b1;
      out_nxt.character = i2ra_pkg::ERR_CHAR;
      out_nxt.last = 1'b1;
      out_nxt.bad_base = 1'b1;
    end else if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_nxt.character = i2ra_pkg::ASCII_MINUS;
      out_nxt.last = 1'b0;
      out_nxt.bad_base = 1'b0;
    end else if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_nxt.character = digit_char;
      out_nxt.last = cnt_r == '0;
      out_nxt.bad_base = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

/* src/i2ra_ctrl.sv */
module i2ra_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  i2ra_pkg::stat_t stat,
  output i2ra_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_SIGN  = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = state_r != ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.bad) begin
          cmd.emit_err = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.last_bit) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (stat.more) begin
          state_nxt = ST_DIV;
        end else if (stat.neg) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.emit_digit = 1'b1;
        state_nxt = stat.cnt_zero ? ST_IDLE : ST_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/integer_to_radix_ascii.sv */
// channel   ports                          transfer
// request   start, busy, in_data           taken when start is high and busy is low
// result    out_valid, out_data            one cycle per character, cannot be held off
//
// a restoring divider forms one quotient bit per cycle; the remainder after a full
// pass over the quotient is the next digit, least significant first; a negative
// value gets a leading minus sign; a bad base gives a lone error result instead
// each digit is read back from the digit store, most significant first, then shown
// synchronous active-low reset returns the controller to idle with no result pending
module integer_to_radix_ascii #(
  parameter int MAX_DIGITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  i2ra_pkg::in_t  in_data,
  output logic           out_valid,
  output i2ra_pkg::out_t out_data
);

  i2ra_pkg::cmd_t  cmd;
  i2ra_pkg::stat_t stat;

  i2ra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  i2ra_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TEXT,
    ROW_ERROR
  } row_kind_t;

  localparam int RANDOM_REQUESTS = 150;
  localparam int DIGIT_SLOTS = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  i2ra_pkg::in_t in_data = '0;
  logic out_valid;
  i2ra_pkg::out_t out_data;

  i2ra_pkg::out_t pending_chars[$];
  i2ra_pkg::in_t row_req[$];
  row_kind_t row_kind[$];
  string row_text[$];
  int mismatches = 0;
  bit calm = 1'b0;

  integer_to_radix_ascii DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  function automatic logic [i2ra_pkg::CHAR_W-1:0] digit_ascii(
      input logic [i2ra_pkg::BASE_W-1:0] d);
    if (d > i2ra_pkg::LAST_DECIMAL) begin
      return i2ra_pkg::LETTER_OFFSET + i2ra_pkg::CHAR_W'(d);
    end
    return i2ra_pkg::ASCII_ZERO + i2ra_pkg::CHAR_W'(d);
  endfunction

  function automatic void push_char(input logic [i2ra_pkg::CHAR_W-1:0] ch, input logic last,
                                    input logic bad);
    i2ra_pkg::out_t item;
    item = {ch, last, bad};
    pending_chars.push_back(item);
  endfunction

  // expected text of one conversion, least significant digit collected first
  function automatic void predict_text(input i2ra_pkg::in_t req);
    logic [i2ra_pkg::VALUE_W-1:0] magnitude;
    logic [i2ra_pkg::VALUE_W-1:0] radix;
    logic [i2ra_pkg::BASE_W-1:0] digits[DIGIT_SLOTS];
    int count;
    logic neg;
    if (req.base < i2ra_pkg::BASE_MIN || req.base > i2ra_pkg::BASE_MAX) begin
      push_char(i2ra_pkg::ERR_CHAR, 1'b1, 1'b1);
      return;
    end
    neg = req.value[i2ra_pkg::VALUE_W-1];
    magnitude = neg ? (~req.value + 1'b1) : req.value;
    radix = i2ra_pkg::VALUE_W'(req.base);
    count = 0;
    do begin
      digits[count] = i2ra_pkg::BASE_W'(magnitude % radix);
      magnitude = magnitude / radix;
      count++;
    end while (magnitude != 0 && count < DIGIT_SLOTS);
    if (neg) begin
      push_char(i2ra_pkg::ASCII_MINUS, 1'b0, 1'b0);
    end
    for (int i = count - 1; i >= 0; i--) begin
      push_char(digit_ascii(digits[i]), i == 0, 1'b0);
    end
  endfunction

  function automatic void push_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      push_char(i2ra_pkg::CHAR_W'(text[i]), i == text.len() - 1, 1'b0);
    end
  endfunction

  function automatic void add_row(input row_kind_t kind,
                                  input logic [i2ra_pkg::VALUE_W-1:0] value,
                                  input logic [i2ra_pkg::BASE_W-1:0] base, input string text);
    i2ra_pkg::in_t req;
    req.value = value;
    req.base = base;
    row_req.push_back(req);
    row_kind.push_back(kind);
    row_text.push_back(text);
  endfunction

  task automatic flag_mismatch(input string what, input i2ra_pkg::out_t got,
                               input i2ra_pkg::out_t want);
    $display("%0t ns mismatch %s: got char %0d last %0b bad %0b, want char %0d last %0b bad %0b",
             $time, what, got.character, got.last, got.bad_base,
             want.character, want.last, want.bad_base);
    mismatches++;
  endtask

  task automatic send_request(input i2ra_pkg::in_t req);
    while (!calm && $urandom_range(99, 0) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    i2ra_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        want = '0;
        flag_mismatch("unexpected character", out_data, want);
      end else begin
        want = pending_chars.pop_front();
        if (out_data.character !== want.character) begin
          flag_mismatch("character", out_data, want);
        end
        if (out_data.last !== want.last) begin
          flag_mismatch("last", out_data, want);
        end
        if (out_data.bad_base !== want.bad_base) begin
          flag_mismatch("bad_base", out_data, want);
        end
      end
    end
  end

  initial begin
    i2ra_pkg::in_t req;
    int pick;
    logic [i2ra_pkg::VALUE_W-1:0] value;

    add_row(ROW_TEXT, 32'd0, 6'd10, "0");
    add_row(ROW_TEXT, 32'd0, 6'd2, "0");
    add_row(ROW_TEXT, 32'h7FFF_FFFF, 6'd10, "2147483647");
    add_row(ROW_TEXT, 32'h8000_0000, 6'd10, "-2147483648");
    add_row(ROW_TEXT, 32'h8000_0000, 6'd2,
            {"-1", "0000000000", "0000000000", "0000000000", "0"});
    add_row(ROW_TEXT, 32'h7FFF_FFFF, 6'd2,
            {"1111111111", "1111111111", "1111111111", "1"});
    add_row(ROW_TEXT, 32'hFFFF_FFFF, 6'd2, "-1");
    add_row(ROW_TEXT, 32'h8000_0000, 6'd16, "-80000000");
    add_row(ROW_PREDICT, 32'h7FFF_FFFF, 6'd36, "");
    add_row(ROW_PREDICT, 32'h8000_0000, 6'd36, "");
    add_row(ROW_TEXT, 32'd35, 6'd36, "Z");
    add_row(ROW_TEXT, 32'd9, 6'd10, "9");
    add_row(ROW_TEXT, 32'd10, 6'd11, "A");
    add_row(ROW_TEXT, 32'd255, 6'd16, "FF");
    add_row(ROW_TEXT, -32'sd255, 6'd16, "-FF");
    add_row(ROW_ERROR, 32'd5, 6'd0, "");
    add_row(ROW_ERROR, 32'hFFFF_FFFF, 6'd1, "");
    add_row(ROW_ERROR, 32'h8000_0000, 6'd37, "");
    add_row(ROW_ERROR, 32'h7FFF_FFFF, 6'd63, "");
    add_row(ROW_PREDICT, 32'd12345, 6'd7, "");
    add_row(ROW_PREDICT, -32'sd987654, 6'd3, "");
    add_row(ROW_PREDICT, 32'd123456789, 6'd35, "");
    add_row(ROW_PREDICT, 32'hDEAD_BEEF, 6'd36, "");
    add_row(ROW_PREDICT, 32'd1, 6'd36, "");

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (row_req[i]) begin
      send_request(row_req[i]);
      case (row_kind[i])
        ROW_TEXT: begin
          push_text(row_text[i]);
        end
        ROW_ERROR: begin
          push_char(i2ra_pkg::ERR_CHAR, 1'b1, 1'b1);
        end
        default: begin
          predict_text(row_req[i]);
        end
      endcase
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      calm = (n >= 60 && n < 110);
      pick = $urandom_range(5, 0);
      case (pick)
        0: value = $urandom;
        1: value = $urandom_range(40, 0);
        2: value = -$urandom_range(40, 1);
        3: begin
          case ($urandom_range(3, 0))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'd0;
            default: value = 32'hFFFF_FFFF;
          endcase
        end
        default: begin
          value = $urandom >> $urandom_range(31, 0);
          if ($urandom_range(1, 0)) begin
            value = -value;
          end
        end
      endcase
      req.value = value;
      if ($urandom_range(99, 0) < 85) begin
        req.base = i2ra_pkg::BASE_W'($urandom_range(36, 2));
      end else if ($urandom_range(2, 0) == 0) begin
        req.base = i2ra_pkg::BASE_W'($urandom_range(1, 0));
      end else begin
        req.base = i2ra_pkg::BASE_W'($urandom_range(63, 37));
      end
      send_request(req);
      predict_text(req);
    end
    start <= 1'b0;

    wait (pending_chars.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

/* files.f */
src/i2ra_pkg.sv
src/i2ra_dp.sv
src/i2ra_ctrl.sv
src/integer_to_radix_ascii.sv
tb/sv/tb_top.sv
